// ----- rtl/mtmf_pkg.sv -----
// ----------------------------------------------------------------------------
// mtmf_pkg
// shared constants and types for the median-then-mode filter
// ----------------------------------------------------------------------------
package mtmf_pkg;

    localparam int SAMPLE_W   = 12;
    localparam int MED_TAPS   = 5;
    localparam int MODE_TAPS  = 8;
    localparam int MED_RANK   = MED_TAPS / 2;
    localparam int MED_IDX_W  = $clog2(MED_TAPS);
    localparam int MED_CNT_W  = $clog2(MED_TAPS + 1);
    localparam int MODE_IDX_W = $clog2(MODE_TAPS);
    localparam int MODE_CNT_W = $clog2(MODE_TAPS + 1);
    localparam int TDATA_W    = ((SAMPLE_W + 7) / 8) * 8;

    typedef logic [SAMPLE_W-1:0] sample_t;

    typedef struct packed {
        logic idle;
        logic done;
    } core_stat_t;

endpackage

// ----- rtl/mtmf_core.sv -----
// ----------------------------------------------------------------------------
// mtmf_core
// window storage and sequencer around one shared compare unit: rank count
// for the median, then equality count for the mode
// ----------------------------------------------------------------------------
module mtmf_core
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  mtmf_pkg::sample_t    sample,
    input  logic                 ack,
    output mtmf_pkg::core_stat_t stat,
    output mtmf_pkg::sample_t    result
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MED   = 3'd1;
    localparam logic [2:0] ST_SHIFT = 3'd2;
    localparam logic [2:0] ST_MODE  = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    localparam int MI_W = (mtmf_pkg::MED_IDX_W > mtmf_pkg::MODE_IDX_W) ?
                          mtmf_pkg::MED_IDX_W : mtmf_pkg::MODE_IDX_W;
    localparam int CN_W = (mtmf_pkg::MED_CNT_W > mtmf_pkg::MODE_CNT_W) ?
                          mtmf_pkg::MED_CNT_W : mtmf_pkg::MODE_CNT_W;

    logic [2:0]        state_reg, state_next;
    logic [MI_W-1:0]   i_reg, i_next;
    logic [MI_W-1:0]   j_reg, j_next;
    logic [CN_W-1:0]   lt_reg, lt_next;
    logic [CN_W-1:0]   le_reg, le_next;
    logic [mtmf_pkg::MODE_CNT_W-1:0] best_cnt_reg, best_cnt_next;
    mtmf_pkg::sample_t best_val_reg, best_val_next;
    mtmf_pkg::sample_t med_reg, med_next;

    mtmf_pkg::sample_t raw_reg [mtmf_pkg::MED_TAPS];
    mtmf_pkg::sample_t mw_reg  [mtmf_pkg::MODE_TAPS];

    // shared compare unit
    mtmf_pkg::sample_t op_a, op_b;
    logic              cmp_lt, cmp_eq;
    logic [CN_W-1:0]   lt_fin, le_fin;
    logic              last_med, last_mode;

    always_comb
    begin
        if (state_reg == ST_MODE)
        begin
            op_a = mw_reg[j_reg[mtmf_pkg::MODE_IDX_W-1:0]];
            op_b = mw_reg[i_reg[mtmf_pkg::MODE_IDX_W-1:0]];
        end
        else
        begin
            op_a = raw_reg[j_reg[mtmf_pkg::MED_IDX_W-1:0]];
            op_b = raw_reg[i_reg[mtmf_pkg::MED_IDX_W-1:0]];
        end
    end

    assign cmp_lt    = op_a < op_b;
    assign cmp_eq    = op_a == op_b;
    assign lt_fin    = lt_reg + CN_W'(cmp_lt);
    assign le_fin    = le_reg + CN_W'(cmp_lt | cmp_eq);
    assign last_med  = j_reg == MI_W'(mtmf_pkg::MED_TAPS - 1);
    assign last_mode = j_reg == MI_W'(mtmf_pkg::MODE_TAPS - 1);

    always_comb
    begin
        state_next    = state_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        lt_next       = lt_reg;
        le_next       = le_reg;
        best_cnt_next = best_cnt_reg;
        best_val_next = best_val_reg;
        med_next      = med_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_MED;
                    i_next     = '0;
                    j_next     = '0;
                    lt_next    = '0;
                    le_next    = '0;
                end
            end
            ST_MED:
            begin
                lt_next = lt_fin;
                le_next = le_fin;
                j_next  = j_reg + 1'b1;
                if (last_med)
                begin
                    // candidate whose rank span covers the middle rank
                    if (lt_fin <= CN_W'(mtmf_pkg::MED_RANK) &&
                        le_fin > CN_W'(mtmf_pkg::MED_RANK))
                    begin
                        med_next = op_b;
                    end
                    lt_next = '0;
                    le_next = '0;
                    j_next  = '0;
                    i_next  = i_reg + 1'b1;
                    if (i_reg == MI_W'(mtmf_pkg::MED_TAPS - 1))
                    begin
                        state_next = ST_SHIFT;
                    end
                end
            end
            ST_SHIFT:
            begin
                state_next    = ST_MODE;
                i_next        = '0;
                j_next        = '0;
                lt_next       = '0;
                best_cnt_next = '0;
                best_val_next = '0;
            end
            ST_MODE:
            begin
                lt_next = lt_reg + CN_W'(cmp_eq);
                j_next  = j_reg + 1'b1;
                if (last_mode)
                begin
                    if (lt_next[mtmf_pkg::MODE_CNT_W-1:0] > best_cnt_reg ||
                        (lt_next[mtmf_pkg::MODE_CNT_W-1:0] == best_cnt_reg &&
                         op_b < best_val_reg))
                    begin
                        best_cnt_next = lt_next[mtmf_pkg::MODE_CNT_W-1:0];
                        best_val_next = op_b;
                    end
                    lt_next = '0;
                    j_next  = '0;
                    i_next  = i_reg + 1'b1;
                    if (i_reg == MI_W'(mtmf_pkg::MODE_TAPS - 1))
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DONE:
            begin
                if (ack)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            i_reg        <= '0;
            j_reg        <= '0;
            lt_reg       <= '0;
            le_reg       <= '0;
            best_cnt_reg <= '0;
            best_val_reg <= '0;
            med_reg      <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            i_reg        <= i_next;
            j_reg        <= j_next;
            lt_reg       <= lt_next;
            le_reg       <= le_next;
            best_cnt_reg <= best_cnt_next;
            best_val_reg <= best_val_next;
            med_reg      <= med_next;
        end
    end

    // windows, oldest at index zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < mtmf_pkg::MED_TAPS; k++)
            begin
                raw_reg[k] <= '0;
            end
            for (int k = 0; k < mtmf_pkg::MODE_TAPS; k++)
            begin
                mw_reg[k] <= '0;
            end
        end
        else
        begin
            if (state_reg == ST_IDLE && start)
            begin
                for (int k = 0; k < mtmf_pkg::MED_TAPS - 1; k++)
                begin
                    raw_reg[k] <= raw_reg[k+1];
                end
                raw_reg[mtmf_pkg::MED_TAPS-1] <= sample;
            end
            if (state_reg == ST_SHIFT)
            begin
                for (int k = 0; k < mtmf_pkg::MODE_TAPS - 1; k++)
                begin
                    mw_reg[k] <= mw_reg[k+1];
                end
                mw_reg[mtmf_pkg::MODE_TAPS-1] <= med_reg;
            end
        end
    end

    assign stat.idle = state_reg == ST_IDLE;
    assign stat.done = state_reg == ST_DONE;
    assign result    = best_val_reg;

    // checks
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> state_reg == ST_IDLE)
        else $error("start outside idle");

    a_start_med: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> state_reg == ST_MED)
        else $error("start did not enter median phase");

    a_ack_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (ack && stat.done) |=> stat.idle)
        else $error("handover did not return to idle");

    a_med_index: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_MED |->
            (i_reg <= MI_W'(mtmf_pkg::MED_TAPS - 1) &&
             j_reg <= MI_W'(mtmf_pkg::MED_TAPS - 1)))
        else $error("median index out of range");

    a_mode_index: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_MODE |->
            (i_reg <= MI_W'(mtmf_pkg::MODE_TAPS - 1) &&
             j_reg <= MI_W'(mtmf_pkg::MODE_TAPS - 1)))
        else $error("mode index out of range");

endmodule

// ----- rtl/median_then_mode_filter.sv -----
// ----------------------------------------------------------------------------
// median_then_mode_filter
// median of the last five samples, then mode of the last eight medians
//
// one 12-bit sample per slave transfer (s_axis), one 12-bit filtered value
// per master transfer (m_axis); every sample gives exactly one result
// a single comparator is swept by a sequencer: 25 compares for the median
// rank count, 64 compares for the mode count, plus start, shift and handover
// steps for each sample
// s_axis_tready is high only while the sequencer is idle; one sample is
// worked on at a time
// the result goes to an output register, so a new sample can be taken while
// the previous result still waits; if the receiver stalls with that register
// full, the next result is held in the core and no further sample is taken
// reset clears both windows to zero and empties the output register
// ----------------------------------------------------------------------------
module median_then_mode_filter
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [mtmf_pkg::TDATA_W-1:0]  s_axis_tdata,   // sample
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [mtmf_pkg::TDATA_W-1:0]  m_axis_tdata    // filtered
);

    mtmf_pkg::core_stat_t stat;
    mtmf_pkg::sample_t    core_result;
    mtmf_pkg::sample_t    out_reg, out_next;
    logic                 valid_reg, valid_next;
    logic                 ack;
    logic                 start;

    assign s_axis_tready = stat.idle;
    assign start         = s_axis_tvalid & stat.idle;
    assign ack           = stat.done & (~valid_reg | m_axis_tready);

    mtmf_core u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .sample (s_axis_tdata[mtmf_pkg::SAMPLE_W-1:0]),
        .ack    (ack),
        .stat   (stat),
        .result (core_result)
    );

    always_comb
    begin
        valid_next = valid_reg;
        out_next   = out_reg;
        if (m_axis_tready)
        begin
            valid_next = 1'b0;
        end
        if (ack)
        begin
            valid_next = 1'b1;
            out_next   = core_result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = mtmf_pkg::TDATA_W'(out_reg);

endmodule
